[hw/rtl/pwe_pkg.sv]
// Package: shared types, codes and cost arithmetic for the path warping energy block.
`default_nettype none
package pwe_pkg;
    localparam int COST_W    = 36;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;
    localparam int START_W   = 10;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_CNT = 3'd5;

    // step directions
    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    // token moving along the cell row (position travels beside it)
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic [COST_W-1:0] left;
        logic [COST_W-1:0] diag;
    } t_tok;

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? COST_MAX : s[COST_W-1:0];
    endfunction
endpackage
`default_nettype wire

[hw/rtl/pwe_ram.sv]
// Generic single-port-write RAM with registered read.
`default_nettype none
module pwe_ram #(
    parameter int W     = 24,
    parameter int DEPTH = 1025
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [W-1:0]             i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/pwe_sqd.sv]
// Squared Euclidean distance between two packed {y, x} grid positions.
`default_nettype none
module pwe_sqd import pwe_pkg::*; #(
    parameter int CW = 12
) (
    input  wire logic [2*CW-1:0]   i_a,
    input  wire logic [2*CW-1:0]   i_b,
    output logic      [COST_W-1:0] o_d
);
    localparam int SW = 2 * (CW + 1);

    logic signed [CW:0]   dx, dy;
    logic signed [SW-1:0] px, py;

    assign dx = $signed({i_a[CW-1], i_a[CW-1:0]}) - $signed({i_b[CW-1], i_b[CW-1:0]});
    assign dy = $signed({i_a[2*CW-1], i_a[2*CW-1:CW]})
              - $signed({i_b[2*CW-1], i_b[2*CW-1:CW]});
    assign px = dx * dx;
    assign py = dy * dy;
    assign o_d = COST_W'($unsigned(px)) + COST_W'($unsigned(py));
endmodule
`default_nettype wire

[hw/rtl/pwe_cell.sv]
// One column cell: holds a second-walk position and its running column cost.
`default_nettype none
module pwe_cell import pwe_pkg::*; #(
    parameter int CW    = 12,
    parameter int CNT_W = 11,
    parameter int IDX   = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CNT_W-1:0] i_m,
    input  wire logic             i_wen,
    input  wire logic [CNT_W-1:0] i_widx,
    input  wire logic [2*CW-1:0]  i_wpos,
    input  wire t_tok             i_tok,
    input  wire logic [2*CW-1:0]  i_pos,
    output t_tok                  o_tok,
    output logic      [2*CW-1:0]  o_pos
);
    logic [2*CW-1:0]   r_s;
    logic [COST_W-1:0] r_c;
    logic              r_vld;
    logic              r_first, r_last;
    logic [COST_W-1:0] r_left, r_diag;

    logic [COST_W-1:0] d, up, best, nc;
    logic              active;

    pwe_sqd #(.CW(CW)) u_sqd (.i_a(i_pos), .i_b(r_s), .o_d(d));

    assign active = CNT_W'(IDX) <= i_m;
    assign up     = i_tok.first ? COST_MAX : r_c;

    always_comb begin
        best = i_tok.left;
        if (up < best) begin
            best = up;
        end
        if (i_tok.diag < best) begin
            best = i_tok.diag;
        end
        nc = sat_add(best, d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wen && i_widx == CNT_W'(IDX)) begin
            r_s <= i_wpos;
        end
        if (i_tok.valid && active) begin
            r_c <= nc;
        end
        r_first <= i_tok.first;
        r_last  <= i_tok.last;
        r_left  <= active ? nc : i_tok.left;   // past the last column: carry through
        r_diag  <= up;
        o_pos   <= i_pos;
    end

    assign o_tok = '{valid: r_vld, first: r_first, last: r_last, left: r_left, diag: r_diag};
endmodule
`default_nettype wire

[hw/rtl/path_warping_energy.sv]
// Top level: walk loading, row feeder, systolic cell row and result register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------
//  in      | sink      | i_in_valid / o_in_stall | i_mode, i_direction
//  out     | source    | o_out_valid / i_out_stall | o_total_energy
//  cfg     | sink      | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// A step item is taken in any cycle in which o_in_stall is low. The item that
// completes both walks starts a sweep of n+1 rows through MAX_STEPS cells; the
// result is taken from the end of the cell row once the last row reaches it.
// Input stalls from the completing item until its result is presented. Steps of
// the next job load while a result is unread; that job's sweep waits for it.
// Reset is synchronous; no memory clearing is needed.
`default_nettype none
module path_warping_energy import pwe_pkg::*; #(
    parameter int MAX_STEPS = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_mode,
    input  wire logic [1:0]           i_direction,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [COST_W-1:0]    o_total_energy
);
    localparam int CNT_W = $clog2(MAX_STEPS + 1);
    localparam int CW    = $clog2(1024 + MAX_STEPS) + 1;   // signed coordinate
    localparam int PW    = 2 * CW;

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_PEND  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    // configuration
    logic [START_W-1:0] r_fsx, r_fsy, r_ssx, r_ssy;
    logic [CFG_W-1:0]   r_fcnt, r_scnt;

    // load state
    logic [1:0]       r_st;
    logic [CNT_W-1:0] r_fl, r_sl, r_n, r_m;
    logic [PW-1:0]    r_fpos, r_spos, r_f0, r_s0;

    // feeder
    logic             r_iss, r_rv, r_rfirst, r_rlast;
    logic [CNT_W-1:0] r_idx;
    logic [COST_W-1:0] r_lcol;
    logic [PW-1:0]    ram_q;
    logic             r_tvld, r_tfirst, r_tlast;
    logic [COST_W-1:0] r_tleft, r_tdiag;
    logic [PW-1:0]    r_tpos;

    // output
    logic              r_ov;
    logic [COST_W-1:0] r_od;

    logic             acc, f_take, s_take, done;
    logic [CNT_W-1:0] eff_n, eff_m, fl_nx, sl_nx;
    logic [PW-1:0]    f_start, s_start, f_new, s_new, feed_pos;
    logic [COST_W-1:0] feed_d, feed_l;

    t_tok          tok  [0:MAX_STEPS];
    logic [PW-1:0] tpos [0:MAX_STEPS];

    function automatic logic [CNT_W-1:0] eff(input logic [CFG_W-1:0] c);
        if (c == '0) begin
            return CNT_W'(1);
        end else if (32'(c) > 32'(MAX_STEPS)) begin
            return CNT_W'(MAX_STEPS);
        end
        return CNT_W'(c);
    endfunction

    function automatic logic [PW-1:0] step_pos(input logic [PW-1:0] p, input logic [1:0] d);
        logic [CW-1:0] x, y;
        x = p[CW-1:0];
        y = p[PW-1:CW];
        unique case (d)
            DIR_N: y = y + CW'(1);
            DIR_E: x = x + CW'(1);
            DIR_S: y = y - CW'(1);
            DIR_W: x = x - CW'(1);
            default: x = x;
        endcase
        return {y, x};
    endfunction

    assign eff_n   = eff(r_fcnt);
    assign eff_m   = eff(r_scnt);
    assign f_start = {CW'(r_fsy), CW'(r_fsx)};
    assign s_start = {CW'(r_ssy), CW'(r_ssx)};

    // a pending result does not block loading; ST_PEND holds the next sweep
    assign o_in_stall = (r_st != ST_LOAD);
    assign acc        = i_in_valid && !o_in_stall;
    assign f_take     = acc && !i_mode && (r_fl < eff_n);
    assign s_take     = acc &&  i_mode && (r_sl < eff_m);
    assign f_new      = step_pos((r_fl == '0) ? f_start : r_fpos, i_direction);
    assign s_new      = step_pos((r_sl == '0) ? s_start : r_spos, i_direction);
    assign fl_nx      = r_fl + CNT_W'(f_take);
    assign sl_nx      = r_sl + CNT_W'(s_take);
    assign done       = acc && (fl_nx >= eff_n) && (sl_nx >= eff_m);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsx  <= '0;
            r_fsy  <= '0;
            r_ssx  <= '0;
            r_ssy  <= '0;
            r_fcnt <= CFG_W'(1);
            r_scnt <= CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIRST_SX:   r_fsx  <= i_cfg_data[START_W-1:0];
                CFG_FIRST_SY:   r_fsy  <= i_cfg_data[START_W-1:0];
                CFG_SECOND_SX:  r_ssx  <= i_cfg_data[START_W-1:0];
                CFG_SECOND_SY:  r_ssy  <= i_cfg_data[START_W-1:0];
                CFG_FIRST_CNT:  r_fcnt <= i_cfg_data;
                CFG_SECOND_CNT: r_scnt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // first walk positions 1..n live in RAM; position 0 in r_f0
    pwe_ram #(.W(PW), .DEPTH(MAX_STEPS + 1)) u_ftrack (
        .i_clk   (i_clk),
        .i_we    (f_take),
        .i_waddr (r_fl + CNT_W'(1)),
        .i_wdata (f_new),
        .i_raddr (r_idx),
        .o_rdata (ram_q)
    );

    // control: load counts, state, feeder sequencing, result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_LOAD;
            r_fl   <= '0;
            r_sl   <= '0;
            r_iss  <= 1'b0;
            r_rv   <= 1'b0;
            r_tvld <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_rv   <= r_iss;
            r_tvld <= r_rv;
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_st)
                ST_LOAD: begin
                    if (done) begin
                        r_fl <= '0;
                        r_sl <= '0;
                        r_st <= ST_PEND;
                    end else begin
                        r_fl <= fl_nx;
                        r_sl <= sl_nx;
                    end
                end
                ST_PEND: begin
                    if (!r_ov) begin
                        r_iss <= 1'b1;
                        r_st  <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    if (r_iss && r_idx == r_n) begin
                        r_iss <= 1'b0;
                    end
                    if (tok[MAX_STEPS].valid && tok[MAX_STEPS].last) begin
                        r_ov <= 1'b1;
                        r_st <= ST_LOAD;
                    end
                end
                default: r_st <= ST_LOAD;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (f_take) begin
            r_fpos <= f_new;
            if (r_fl == '0) begin
                r_f0 <= f_start;
            end
        end
        if (s_take) begin
            r_spos <= s_new;
            if (r_sl == '0) begin
                r_s0 <= s_start;
            end
        end
        if (done) begin
            r_n <= eff_n;
            r_m <= eff_m;
        end
        if (r_st == ST_PEND) begin
            r_idx <= '0;
        end else if (r_iss) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        r_rfirst <= (r_idx == '0);
        r_rlast  <= (r_idx == r_n);
        // column 0 of the table, one row per cycle
        if (r_rv) begin
            r_lcol <= feed_l;
        end
        r_tfirst <= r_rfirst;
        r_tlast  <= r_rlast;
        r_tleft  <= feed_l;
        r_tdiag  <= r_rfirst ? COST_MAX : r_lcol;
        r_tpos   <= feed_pos;
        if (r_st == ST_SWEEP && tok[MAX_STEPS].valid && tok[MAX_STEPS].last) begin
            r_od <= tok[MAX_STEPS].left;
        end
    end

    assign feed_pos = r_rfirst ? r_f0 : ram_q;

    pwe_sqd #(.CW(CW)) u_sqd0 (.i_a(feed_pos), .i_b(r_s0), .o_d(feed_d));

    assign feed_l = r_rfirst ? '0 : sat_add(r_lcol, feed_d);

    assign tok[0]  = '{valid: r_tvld, first: r_tfirst, last: r_tlast,
                       left: r_tleft, diag: r_tdiag};
    assign tpos[0] = r_tpos;

    // one cell per column of the second walk
    for (genvar k = 1; k <= MAX_STEPS; k++) begin : g_cell
        pwe_cell #(.CW(CW), .CNT_W(CNT_W), .IDX(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_m     (r_m),
            .i_wen   (s_take),
            .i_widx  (r_sl + CNT_W'(1)),
            .i_wpos  (s_new),
            .i_tok   (tok[k-1]),
            .i_pos   (tpos[k-1]),
            .o_tok   (tok[k]),
            .o_pos   (tpos[k])
        );
    end

    assign o_out_valid    = r_ov;
    assign o_total_energy = r_od;
endmodule
`default_nettype wire

[hw/rtl/pwe_chk.sv]
// Port-level checker for the path warping energy block, with its bind.
`default_nettype none
module pwe_chk import pwe_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [COST_W-1:0] o_total_energy
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_total_energy))
        else $error("result changed while stalled");

    a_result_after_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a preceding sweep");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall |=> !o_out_valid)
        else $error("result repeated after it was taken");
endmodule

bind path_warping_energy pwe_chk u_pwe_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_total_energy (o_total_energy)
);
`default_nettype wire
